[design/ocp_pkg.sv]
// shared types and constants for the omnidirectional camera projector
`default_nettype none

package ocp_pkg;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 28;
    localparam logic [CFG_AW-1:0] REG_CENTER_FIRST  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_CENTER_SECOND = 3'd1;
    localparam logic [CFG_AW-1:0] REG_AFFINE_C      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_AFFINE_D      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_AFFINE_E      = 3'd4;
    localparam logic [CFG_AW-1:0] REG_POLY_TERMS    = 3'd5;

    // last count value of each iterative phase
    localparam logic [5:0] SQRT_LAST   = 6'd31;
    localparam logic [5:0] CORDIC_LAST = 6'd23;
    localparam logic [5:0] DIV_LAST    = 6'd54;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CAPTURE,
        OP_SQ_X,
        OP_SQ_Y,
        OP_AXIS,
        OP_SQRT,
        OP_CORDIC_INIT,
        OP_CORDIC,
        OP_RHO_INIT,
        OP_H_HI,
        OP_H_LO,
        OP_DIV_INIT,
        OP_DIV,
        OP_UX_HI,
        OP_UX_LO,
        OP_UY_HI,
        OP_UY_LO,
        OP_XP_HI,
        OP_XP_LO,
        OP_YP_HI,
        OP_YP_LO,
        OP_FC_HI,
        OP_FC_LO,
        OP_FD_HI,
        OP_FD_LO,
        OP_F_OUT,
        OP_SE_HI,
        OP_SE_LO,
        OP_S_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic       rd_en;
    } cmd_t;

    typedef struct packed {
        logic n2_zero;
    } status_t;

endpackage

`default_nettype wire

[design/omni_camera_project.sv]
// Omnidirectional world-to-image projector. A start beat with op=0 writes one
// polynomial coefficient and completes in the cycle it is taken (busy stays low);
// a start beat with op=1 projects a ray and raises busy until the result. A
// projection runs a bit-serial square root, 24 CORDIC steps, a Horner pass
// with a high and a low multiplier product per term beyond the first of the
// clamped term count, a radix-2 divider, and the scaling and the affine map
// on the shared 34x26 multiplier. A ray with zero in-plane norm returns the
// image center. Each result is on the output ports for the one cycle that
// done is high; the receiver must take it then. Configuration writes must
// only be made while the block is idle.
`default_nettype none

module omni_camera_project #(
    parameter int MAX_TERMS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [3:0]          coeff_index,
    input  logic signed [47:0]  coeff_value,
    input  logic signed [23:0]  ray_x,
    input  logic signed [23:0]  ray_y,
    input  logic signed [23:0]  ray_z,
    input  logic                cfg_we,
    input  logic [ocp_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [ocp_pkg::CFG_DW-1:0] cfg_data,
    output logic                done,
    output logic signed [31:0]  pixel_first,
    output logic signed [31:0]  pixel_second,
    output logic                on_axis,
    output logic                saturated
);
    import ocp_pkg::*;

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    logic [27:0]        center_first_reg, center_second_reg;
    logic signed [20:0] affine_c_reg, affine_d_reg, affine_e_reg;
    logic [4:0]         poly_terms_reg;

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] rd_addr;

    // configuration register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_first_reg  <= '0;
            center_second_reg <= '0;
            affine_c_reg      <= 21'sd65536;
            affine_d_reg      <= '0;
            affine_e_reg      <= '0;
            poly_terms_reg    <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_FIRST:  center_first_reg  <= cfg_data;
                REG_CENTER_SECOND: center_second_reg <= cfg_data;
                REG_AFFINE_C:      affine_c_reg      <= $signed(cfg_data[20:0]);
                REG_AFFINE_D:      affine_d_reg      <= $signed(cfg_data[20:0]);
                REG_AFFINE_E:      affine_e_reg      <= $signed(cfg_data[20:0]);
                REG_POLY_TERMS:    poly_terms_reg    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer
    ocp_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .poly_terms (poly_terms_reg),
        .status     (status),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .busy       (busy),
        .done       (done)
    );

    // arithmetic and coefficient storage
    ocp_datapath #(
        .MAX_TERMS (MAX_TERMS),
        .AW        (AW)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .status        (status),
        .coeff_index   (coeff_index),
        .coeff_value   (coeff_value),
        .ray_x         (ray_x),
        .ray_y         (ray_y),
        .ray_z         (ray_z),
        .center_first  (center_first_reg),
        .center_second (center_second_reg),
        .affine_c      (affine_c_reg),
        .affine_d      (affine_d_reg),
        .affine_e      (affine_e_reg),
        .pixel_first   (pixel_first),
        .pixel_second  (pixel_second),
        .on_axis       (on_axis),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire

[design/ocp_ctrl.sv]
// sequencer that steps the projection datapath through its phases
`default_nettype none

module ocp_ctrl #(
    parameter int MAX_TERMS = 16,
    parameter int AW        = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               op,
    input  logic [4:0]         poly_terms,
    input  ocp_pkg::status_t   status,
    output ocp_pkg::cmd_t      cmd,
    output logic [AW-1:0]      rd_addr,
    output logic               busy,
    output logic               done
);
    import ocp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_CHECK, S_SQRT, S_CINIT, S_CORDIC, S_RHO,
        S_HHI, S_HLO, S_DINIT, S_DIV, S_UXH, S_UXL, S_UYH, S_UYL,
        S_XPH, S_XPL, S_YPH, S_YPL, S_FCH, S_FCL, S_FDH, S_FDL, S_FOUT,
        S_SEH, S_SEL, S_SOUT
    } state_t;

    localparam logic [5:0] MaxT6 = 6'(MAX_TERMS);

    state_t        state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [AW-1:0] kidx_reg, kidx_next;
    logic          done_reg, done_next;
    logic [5:0]    terms6;
    logic [AW-1:0] last_idx;

    // clamp the term count to the table
    always_comb
    begin
        if (poly_terms == 5'd0)
            terms6 = 6'd1;
        else if (6'(poly_terms) > MaxT6)
            terms6 = MaxT6;
        else
            terms6 = 6'(poly_terms);
        last_idx = AW'(terms6 - 6'd1);
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        kidx_next  = kidx_reg;
        done_next  = 1'b0;
        cmd.op     = OP_NOP;
        cmd.step   = cnt_reg[4:0];
        cmd.rd_en  = 1'b0;
        rd_addr    = last_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op)
                    begin
                        cmd.op     = OP_CAPTURE;
                        state_next = S_SQX;
                    end
                    else
                        cmd.op = OP_LOAD;
                end
            end
            S_SQX:
            begin
                cmd.op     = OP_SQ_X;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQ_Y;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (status.n2_zero)
                begin
                    cmd.op     = OP_AXIS;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.op     = OP_CORDIC_INIT;
                cmd.rd_en  = 1'b1;
                kidx_next  = last_idx;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cmd.op   = OP_CORDIC;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_RHO;
            end
            S_RHO:
            begin
                cmd.op = OP_RHO_INIT;
                if (kidx_reg == '0)
                    state_next = S_DINIT;
                else
                    state_next = S_HHI;
            end
            S_HHI:
            begin
                cmd.op     = OP_H_HI;
                cmd.rd_en  = 1'b1;
                rd_addr    = kidx_reg - AW'(1);
                state_next = S_HLO;
            end
            S_HLO:
            begin
                cmd.op    = OP_H_LO;
                kidx_next = kidx_reg - AW'(1);
                if (kidx_reg == AW'(1))
                    state_next = S_DINIT;
                else
                    state_next = S_HHI;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_UXH;
            end
            S_UXH: begin cmd.op = OP_UX_HI; state_next = S_UXL; end
            S_UXL: begin cmd.op = OP_UX_LO; state_next = S_UYH; end
            S_UYH: begin cmd.op = OP_UY_HI; state_next = S_UYL; end
            S_UYL: begin cmd.op = OP_UY_LO; state_next = S_XPH; end
            S_XPH: begin cmd.op = OP_XP_HI; state_next = S_XPL; end
            S_XPL: begin cmd.op = OP_XP_LO; state_next = S_YPH; end
            S_YPH: begin cmd.op = OP_YP_HI; state_next = S_YPL; end
            S_YPL: begin cmd.op = OP_YP_LO; state_next = S_FCH; end
            S_FCH: begin cmd.op = OP_FC_HI; state_next = S_FCL; end
            S_FCL: begin cmd.op = OP_FC_LO; state_next = S_FDH; end
            S_FDH: begin cmd.op = OP_FD_HI; state_next = S_FDL; end
            S_FDL: begin cmd.op = OP_FD_LO; state_next = S_FOUT; end
            S_FOUT: begin cmd.op = OP_F_OUT; state_next = S_SEH; end
            S_SEH: begin cmd.op = OP_SE_HI; state_next = S_SEL; end
            S_SEL: begin cmd.op = OP_SE_LO; state_next = S_SOUT; end
            S_SOUT:
            begin
                cmd.op     = OP_S_OUT;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            kidx_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            kidx_reg  <= kidx_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

[design/ocp_datapath.sv]
// projection datapath: shared multiplier, sqrt, cordic, divider, coefficient table
`default_nettype none

module ocp_datapath #(
    parameter int MAX_TERMS = 16,
    parameter int AW        = 4
) (
    input  logic                clk,
    input  ocp_pkg::cmd_t       cmd,
    input  logic [AW-1:0]       rd_addr,
    output ocp_pkg::status_t    status,
    input  logic [3:0]          coeff_index,
    input  logic signed [47:0]  coeff_value,
    input  logic signed [23:0]  ray_x,
    input  logic signed [23:0]  ray_y,
    input  logic signed [23:0]  ray_z,
    input  logic [27:0]         center_first,
    input  logic [27:0]         center_second,
    input  logic signed [20:0]  affine_c,
    input  logic signed [20:0]  affine_d,
    input  logic signed [20:0]  affine_e,
    output logic signed [31:0]  pixel_first,
    output logic signed [31:0]  pixel_second,
    output logic                on_axis,
    output logic                saturated
);
    import ocp_pkg::*;

    localparam logic signed [49:0] PixMax = 50'sd2147483647;
    localparam logic signed [49:0] PixMin = -50'sd2147483648;
    localparam logic signed [51:0] RhoMax = 52'sd140737488355327;
    localparam logic signed [51:0] RhoMin = -52'sd140737488355328;

    logic signed [47:0] coeff_mem [MAX_TERMS];

    logic signed [23:0] x_reg, y_reg, z_reg;
    logic signed [49:0] acc_reg;
    logic [63:0]        v_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        root_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [25:0] theta_reg;
    logic signed [47:0] rho_reg, k_reg;
    logic [31:0]        drem_reg;
    logic [54:0]        q_reg;
    logic signed [56:0] t_reg;
    logic signed [32:0] ux_reg, uy_reg;
    logic signed [40:0] xp_reg, yp_reg;
    logic signed [31:0] pf_reg, ps_reg;
    logic               axis_reg, sat_reg, satout_reg;

    logic signed [33:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [59:0] prod;

    logic [35:0]        rem_sh, trial;
    logic               sq_ge;
    logic [32:0]        rem2;
    logic               div_ge;
    logic signed [35:0] dx, dy;
    logic signed [25:0] atan_a;
    logic signed [51:0] hsum;
    logic [47:0]        n2;

    // cordic angle for step i, Q.24
    function automatic logic signed [25:0] atan_val(input logic [4:0] i);
        logic signed [25:0] a;
        case (i)
            5'd0: a = 26'sd13176795;
            5'd1: a = 26'sd7778716;
            5'd2: a = 26'sd4110060;
            5'd3: a = 26'sd2086331;
            5'd4: a = 26'sd1047214;
            5'd5: a = 26'sd524117;
            5'd6: a = 26'sd262123;
            5'd7: a = 26'sd131069;
            default: a = 26'sd1 <<< (5'd24 - i);
        endcase
        return a;
    endfunction

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op) inside
            OP_SQ_X:
            begin
                mul_a = 34'(x_reg);
                mul_b = 26'(x_reg);
            end
            OP_SQ_Y:
            begin
                mul_a = 34'(y_reg);
                mul_b = 26'(y_reg);
            end
            OP_H_HI:
            begin
                mul_a = 34'(theta_reg);
                mul_b = 26'($signed(rho_reg[47:24]));
            end
            OP_H_LO:
            begin
                mul_a = 34'(theta_reg);
                mul_b = 26'($signed({1'b0, rho_reg[23:0]}));
            end
            OP_UX_HI, OP_UY_HI:
            begin
                mul_a = 34'($signed({1'b0, q_reg[54:28]}));
                mul_b = (cmd.op == OP_UX_HI) ? 26'(x_reg) : 26'(y_reg);
            end
            OP_UX_LO, OP_UY_LO:
            begin
                mul_a = 34'($signed({1'b0, q_reg[27:0]}));
                mul_b = (cmd.op == OP_UX_LO) ? 26'(x_reg) : 26'(y_reg);
            end
            OP_XP_HI, OP_YP_HI:
            begin
                mul_a = (cmd.op == OP_XP_HI) ? 34'(ux_reg) : 34'(uy_reg);
                mul_b = 26'($signed(rho_reg[47:24]));
            end
            OP_XP_LO, OP_YP_LO:
            begin
                mul_a = (cmd.op == OP_XP_LO) ? 34'(ux_reg) : 34'(uy_reg);
                mul_b = 26'($signed({1'b0, rho_reg[23:0]}));
            end
            OP_FC_HI:
            begin
                mul_a = 34'(affine_c);
                mul_b = 26'($signed(xp_reg[40:20]));
            end
            OP_FC_LO:
            begin
                mul_a = 34'(affine_c);
                mul_b = 26'($signed({1'b0, xp_reg[19:0]}));
            end
            OP_FD_HI:
            begin
                mul_a = 34'(affine_d);
                mul_b = 26'($signed(yp_reg[40:20]));
            end
            OP_FD_LO:
            begin
                mul_a = 34'(affine_d);
                mul_b = 26'($signed({1'b0, yp_reg[19:0]}));
            end
            OP_SE_HI:
            begin
                mul_a = 34'(affine_e);
                mul_b = 26'($signed(xp_reg[40:20]));
            end
            OP_SE_LO:
            begin
                mul_a = 34'(affine_e);
                mul_b = 26'($signed({1'b0, xp_reg[19:0]}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // step logic of the iterative units
    always_comb
    begin
        n2     = 48'(acc_reg) + 48'(prod);
        rem_sh = {rem_reg, v_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        sq_ge  = (rem_sh >= trial);
        rem2   = {drem_reg, 1'b0};
        div_ge = (rem2 >= {1'b0, root_reg});
        dx     = cy_reg >>> cmd.step;
        dy     = cx_reg >>> cmd.step;
        atan_a = atan_val(cmd.step);
        hsum   = 52'(t_reg) + 52'(prod >>> 24) + 52'(k_reg);
    end

    assign status.n2_zero = (v_reg == '0);

    // datapath registers and coefficient table
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            k_reg <= coeff_mem[rd_addr];
        case (cmd.op)
            OP_LOAD:
            begin
                if (int'(coeff_index) < MAX_TERMS)
                    coeff_mem[AW'(coeff_index)] <= coeff_value;
            end
            OP_CAPTURE:
            begin
                x_reg   <= ray_x;
                y_reg   <= ray_y;
                z_reg   <= ray_z;
                sat_reg <= 1'b0;
            end
            OP_SQ_X: acc_reg <= 50'(prod);
            OP_SQ_Y:
            begin
                v_reg    <= {n2, 16'h0000};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_AXIS:
            begin
                pf_reg     <= $signed({4'b0000, center_first});
                ps_reg     <= $signed({4'b0000, center_second});
                axis_reg   <= 1'b1;
                satout_reg <= 1'b0;
            end
            OP_SQRT:
            begin
                v_reg    <= {v_reg[61:0], 2'b00};
                rem_reg  <= sq_ge ? 34'(rem_sh - trial) : 34'(rem_sh);
                root_reg <= {root_reg[30:0], sq_ge};
            end
            OP_CORDIC_INIT:
            begin
                cx_reg    <= $signed({4'b0000, root_reg});
                cy_reg    <= {{4{z_reg[23]}}, z_reg, 8'h00};
                theta_reg <= '0;
            end
            OP_CORDIC:
            begin
                if (!cy_reg[35])
                begin
                    cx_reg    <= cx_reg + dx;
                    cy_reg    <= cy_reg - dy;
                    theta_reg <= theta_reg + atan_a;
                end
                else
                begin
                    cx_reg    <= cx_reg - dx;
                    cy_reg    <= cy_reg + dy;
                    theta_reg <= theta_reg - atan_a;
                end
            end
            OP_RHO_INIT: rho_reg <= k_reg;
            OP_H_HI: t_reg <= 57'(prod);
            OP_H_LO:
            begin
                if (hsum > RhoMax)
                begin
                    rho_reg <= 48'(RhoMax);
                    sat_reg <= 1'b1;
                end
                else if (hsum < RhoMin)
                begin
                    rho_reg <= 48'(RhoMin);
                    sat_reg <= 1'b1;
                end
                else
                    rho_reg <= 48'(hsum);
            end
            OP_DIV_INIT:
            begin
                drem_reg <= 32'd128;
                q_reg    <= '0;
            end
            OP_DIV:
            begin
                drem_reg <= div_ge ? 32'(rem2 - {1'b0, root_reg}) : 32'(rem2);
                q_reg    <= {q_reg[53:0], div_ge};
            end
            OP_UX_HI, OP_UY_HI, OP_XP_HI, OP_YP_HI:
            begin
                if (cmd.op == OP_UX_HI || cmd.op == OP_UY_HI)
                    t_reg <= 57'(prod <<< 4);
                else
                    t_reg <= 57'(prod);
            end
            OP_UX_LO: ux_reg <= 33'(t_reg + 57'(prod >>> 24));
            OP_UY_LO: uy_reg <= 33'(t_reg + 57'(prod >>> 24));
            OP_XP_LO: xp_reg <= 41'((t_reg + 57'(prod >>> 24)) >>> 14);
            OP_YP_LO: yp_reg <= 41'((t_reg + 57'(prod >>> 24)) >>> 14);
            OP_FC_HI: acc_reg <= $signed({22'h0, center_first}) + 50'(prod <<< 4);
            OP_FD_HI: acc_reg <= acc_reg + 50'(prod <<< 4);
            OP_FC_LO, OP_FD_LO, OP_SE_LO: acc_reg <= acc_reg + 50'(prod >>> 16);
            OP_SE_HI:
                acc_reg <= $signed({22'h0, center_second}) + 50'(yp_reg)
                           + 50'(prod <<< 4);
            OP_F_OUT:
            begin
                if (acc_reg > PixMax)
                begin
                    pf_reg  <= 32'(PixMax);
                    sat_reg <= 1'b1;
                end
                else if (acc_reg < PixMin)
                begin
                    pf_reg  <= 32'(PixMin);
                    sat_reg <= 1'b1;
                end
                else
                    pf_reg <= 32'(acc_reg);
            end
            OP_S_OUT:
            begin
                axis_reg <= 1'b0;
                if (acc_reg > PixMax)
                begin
                    ps_reg     <= 32'(PixMax);
                    satout_reg <= 1'b1;
                end
                else if (acc_reg < PixMin)
                begin
                    ps_reg     <= 32'(PixMin);
                    satout_reg <= 1'b1;
                end
                else
                begin
                    ps_reg     <= 32'(acc_reg);
                    satout_reg <= sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign pixel_first  = pf_reg;
    assign pixel_second = ps_reg;
    assign on_axis      = axis_reg;
    assign saturated    = satout_reg;

endmodule

`default_nettype wire

[design/ocp_checker.sv]
// port-level checks of the projector and their attachment to the top level
`default_nettype none

module ocp_sva (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                op,
    input  logic                done,
    input  logic                on_axis,
    input  logic                saturated
);

    // a coefficient load beat never occupies the block
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !op |=> !busy)
        else $error("load beat left the block busy");

    // a projection beat always occupies the block
    a_proj_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op |=> busy)
        else $error("projection beat did not raise busy");

    // the result strobe lasts one cycle and the block is free by then
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy ##1 !done)
        else $error("result strobe longer than one cycle or block still busy");

    // an on-axis result is never marked clipped
    a_axis_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        done && on_axis |-> !saturated)
        else $error("on-axis result marked saturated");

endmodule

bind omni_camera_project ocp_sva u_ocp_sva (.*);

`default_nettype wire

[dv/ocp_checker.sv]
// checker for the omnidirectional projector: watches the ports, predicts and compares
module ocp_checker
    import ocp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 op,
    input  logic [3:0]           coeff_index,
    input  logic signed [47:0]   coeff_value,
    input  logic signed [23:0]   ray_x,
    input  logic signed [23:0]   ray_y,
    input  logic signed [23:0]   ray_z,
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 done,
    input  logic signed [31:0]   pixel_first,
    input  logic signed [31:0]   pixel_second,
    input  logic                 on_axis,
    input  logic                 saturated,
    output int                   errors,
    output int                   pending,
    output int                   n_checked,
    output int                   n_axis,
    output int                   n_sat
);

    localparam int TERMS_MAX = 16;

    typedef struct {
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               axis;
        logic               sat;
    } pixel_t;

    // angle steps for the first eight rotations, Q.24
    localparam longint ATAN_STEP [8] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069
    };

    pixel_t                pixel_q[$];
    logic [27:0]           ctr_first, ctr_second;
    longint                aff_c, aff_d, aff_e;
    logic [4:0]            n_terms;
    longint                coeffs [TERMS_MAX];

    assign pending = pixel_q.size();

    // floor(a*b / 2^s) with the magnitude clipped to 2^62
    function automatic longint mul_shift(longint a, longint b, int s);
        logic         neg;
        logic [127:0] ua, ub, prod, q, rest;
        logic [63:0]  r;
        neg  = (a < 0) != (b < 0);
        ua   = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
        ub   = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
        prod = ua * ub;
        q    = prod >> s;
        rest = prod & ((128'd1 << s) - 128'd1);
        if (q > (128'd1 << 62))
            r = 64'd1 << 62;
        else
            r = q[63:0] + ((neg && rest != 0) ? 64'd1 : 64'd0);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi, inout logic sat);
        if (v < lo)
        begin
            sat = 1'b1;
            return lo;
        end
        if (v > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        return v;
    endfunction

    // one projected pixel from the ray and the current calibration
    function automatic pixel_t project_ray(longint x, longint y, longint z);
        pixel_t          px;
        longint unsigned n2, norm, inv;
        longint          cx, cy, theta, a, dx, dy, rho, ux, uy, xp, yp, f, s;
        int              terms;
        logic            sat;
        sat = 1'b0;
        n2  = longint'(x * x) + longint'(y * y);
        if (n2 == 0)
        begin
            px.first  = 32'(ctr_first);
            px.second = 32'(ctr_second);
            px.axis   = 1'b1;
            px.sat    = 1'b0;
            return px;
        end
        norm = int_sqrt(n2 << 16);
        // vectoring rotations give theta = atan(256 * z / norm)
        cx    = longint'(norm);
        cy    = z * 256;
        theta = 0;
        for (int i = 0; i < 24; i++)
        begin
            a  = (i < 8) ? ATAN_STEP[i] : (longint'(1) << (24 - i));
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                theta = theta + a;
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                theta = theta - a;
            end
        end
        // horner pass over the active coefficients
        terms = (n_terms == 0) ? 1 : ((n_terms > TERMS_MAX) ? TERMS_MAX : int'(n_terms));
        rho = coeffs[terms-1];
        for (int k = terms - 2; k >= 0; k--)
            rho = clip(mul_shift(rho, theta, 24) + coeffs[k],
                       -(longint'(1) << 47), (longint'(1) << 47) - 1, sat);
        inv = (64'd1 << 62) / norm;
        ux  = mul_shift(x, longint'(inv), 24);
        uy  = mul_shift(y, longint'(inv), 24);
        xp  = mul_shift(rho, ux, 38);
        yp  = mul_shift(rho, uy, 38);
        f = mul_shift(xp, aff_c, 16) + mul_shift(yp, aff_d, 16) + longint'(ctr_first);
        s = mul_shift(xp, aff_e, 16) + yp + longint'(ctr_second);
        f = clip(f, -64'sd2147483648, 64'sd2147483647, sat);
        s = clip(s, -64'sd2147483648, 64'sd2147483647, sat);
        px.first  = f[31:0];
        px.second = s[31:0];
        px.axis   = 1'b0;
        px.sat    = sat;
        return px;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // track calibration writes and accepted beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_first  <= '0;
            ctr_second <= '0;
            aff_c      <= 65536;
            aff_d      <= 0;
            aff_e      <= 0;
            n_terms    <= 5'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_CENTER_FIRST:  ctr_first  <= cfg_data;
                    REG_CENTER_SECOND: ctr_second <= cfg_data;
                    REG_AFFINE_C:      aff_c <= longint'(signed'(cfg_data[20:0]));
                    REG_AFFINE_D:      aff_d <= longint'(signed'(cfg_data[20:0]));
                    REG_AFFINE_E:      aff_e <= longint'(signed'(cfg_data[20:0]));
                    REG_POLY_TERMS:    n_terms <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (!op)
                    coeffs[coeff_index] = longint'(coeff_value);
                else
                    pixel_q.push_back(project_ray(ray_x, ray_y, ray_z));
            end
        end
    end

    // compare each result beat against the oldest prediction
    initial
    begin
        errors = 0;
        n_checked = 0;
        n_axis = 0;
        n_sat = 0;
        foreach (coeffs[i])
            coeffs[i] = 0;
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && done)
        begin
            if (pixel_q.size() == 0)
            begin
                $display("mismatch at %0t: result beat with nothing predicted", $realtime);
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                n_checked++;
                if (want.axis)
                    n_axis++;
                if (want.sat)
                    n_sat++;
                if (pixel_first !== want.first)
                    report("pixel_first", pixel_first, want.first);
                if (pixel_second !== want.second)
                    report("pixel_second", pixel_second, want.second);
                if (on_axis !== want.axis)
                    report("on_axis", on_axis, want.axis);
                if (saturated !== want.sat)
                    report("saturated", saturated, want.sat);
            end
        end
    end

endmodule

[dv/tb.sv]
// testbench top for the omnidirectional projector: stimulus, calibration phases, verdict
module tb;
    import ocp_pkg::*;

    localparam int DRAIN = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                op = 1'b0;
    logic [3:0]          coeff_index = '0;
    logic signed [47:0]  coeff_value = '0;
    logic signed [23:0]  ray_x = '0;
    logic signed [23:0]  ray_y = '0;
    logic signed [23:0]  ray_z = '0;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    logic                busy, done, on_axis, saturated;
    logic signed [31:0]  pixel_first, pixel_second;
    int                  errors, pending, n_checked, n_axis, n_sat;
    int                  idle_pct;
    int                  n_loads;

    always #1 clk = ~clk;

    omni_camera_project dut (.*);
    ocp_checker chk (.*);

    // sender gap, then one beat held until taken
    task automatic send(logic o, logic [3:0] idx, logic [47:0] val,
                        logic [23:0] x, logic [23:0] y, logic [23:0] z);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        op          <= o;
        coeff_index <= idx;
        coeff_value <= val;
        ray_x       <= x;
        ray_y       <= y;
        ray_z       <= z;
        if (!o)
            n_loads++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // stop sending and let every pending pixel come out
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_cfg(logic [27:0] cf, logic [27:0] cs, logic [20:0] c,
                             logic [20:0] d, logic [20:0] e, logic [4:0] terms);
        logic [27:0] vals [6];
        vals = '{cf, cs, 28'(c), 28'(d), 28'(e), 28'(terms)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_AW'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] pick_comp();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'(int'($urandom_range(2)) - 1);
            3: return 24'($urandom());
            default: return 24'(int'($urandom_range(8191)) - 4096);
        endcase
    endfunction

    // coefficient: mostly plausible calibration magnitudes, sometimes anything
    function automatic logic [47:0] pick_coeff(int slot);
        if ($urandom_range(9) < 3)
            return 48'({$urandom(), $urandom()});
        if (slot == 0)
            return 48'(longint'($urandom_range(600)) << 24);
        return 48'(longint'(int'($urandom_range(65535)) - 32768) << ($urandom_range(16)));
    endfunction

    task automatic random_phase(int count);
        logic [23:0] x, y;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 12)
                send(1'b0, 4'($urandom()), pick_coeff(int'($urandom_range(15))),
                     24'($urandom()), 24'($urandom()), 24'($urandom()));
            else
            begin
                x = pick_comp();
                y = pick_comp();
                if ($urandom_range(19) == 0)
                begin
                    x = '0;
                    y = '0;
                end
                send(1'b1, 4'($urandom()), 48'({$urandom(), $urandom()}), x, y,
                     pick_comp());
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        idle_pct = 0;
        n_loads = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill the table, extremes of rays and coefficients
        write_cfg(28'h2800000, 28'h1e00000, 21'd65536, 21'd0, 21'd0, 5'd16);
        for (int i = 0; i < 16; i++)
            send(1'b0, 4'(i), (i == 15) ? 48'h7fffffffffff : pick_coeff(i),
                 '0, '0, '0);
        send(1'b1, '0, '0, 24'd0, 24'd0, 24'd0);
        send(1'b1, '0, '0, 24'd0, 24'd0, 24'h7fffff);
        send(1'b1, '0, '0, 24'h7fffff, 24'h7fffff, 24'h800000);
        send(1'b1, '0, '0, 24'h800000, 24'd0, 24'h7fffff);
        send(1'b1, '0, '0, 24'd0, 24'hffffff, 24'd0);
        drain();
        write_cfg(28'h2800000, 28'h1e00000, 21'd65536, 21'd0, 21'd0, 5'd3);
        send(1'b0, 4'd15, 48'h800000000000, '0, '0, '0);
        send(1'b0, 4'd2, 48'd0, '0, '0, '0);
        send(1'b1, '0, '0, 24'd100, 24'hffff9c, 24'd50);
        send(1'b1, '0, '0, 24'd1, 24'd0, 24'h800000);

        // random phases: calm, sender idling, again calm at extremes, mixed
        idle_pct = 0;
        random_phase(160);
        drain();
        write_cfg(28'hfffffff, 28'hfffffff, 21'h0fffff, 21'h100000, 21'h0fffff, 5'd31);
        idle_pct = 75;
        random_phase(160);
        drain();
        write_cfg(28'd0, 28'd0, 21'h100000, 21'h0fffff, 21'h100000, 5'd0);
        idle_pct = 0;
        random_phase(160);
        drain();
        write_cfg(28'($urandom()), 28'($urandom()), 21'($urandom()), 21'($urandom()),
                  21'($urandom()), 5'($urandom_range(1, 16)));
        idle_pct = 38;
        random_phase(170);
        drain();

        $display("covered %0d pixels checked (%0d on axis, %0d saturated), %0d table loads",
                 n_checked, n_axis, n_sat, n_loads);
        $display("five calibration settings, sender gaps of none, 38 and 75 percent");
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[sim.f]
design/ocp_pkg.sv
design/ocp_ctrl.sv
design/ocp_datapath.sv
design/omni_camera_project.sv
design/ocp_checker.sv
dv/ocp_checker.sv
dv/tb.sv
